// ----- hw/rtl/hrtp_pkg.sv -----
`timescale 1ns / 1ps

package hrtp_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [5:0] NUT_TRAIL_R = 6'd1;
	localparam logic [5:0] NUT_BLA_W   = 6'd16;
	localparam logic [5:0] NUT_VPS     = 6'd32;
	localparam logic [5:0] NUT_SPS     = 6'd33;
	localparam logic [5:0] NUT_PPS     = 6'd34;
	localparam logic [5:0] NUT_SEI     = 6'd39;
	localparam logic [5:0] NUT_FU      = 6'd49;

	localparam logic [1:0] SE_START = 2'b10;
	localparam logic [1:0] SE_BOTH  = 2'b11;

	localparam logic [7:0] HDR_KEEP_MASK = 8'h81;
	localparam logic [7:0] SC_ZERO       = 8'h00;
	localparam logic [7:0] SC_ONE        = 8'h01;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_PASS,
		MODE_FU_NUH2,
		MODE_FU_HDR,
		MODE_DROP
	} hrtp_mode_t;

	typedef enum logic [2:0] {
		STEP_Z0,
		STEP_Z1,
		STEP_Z2,
		STEP_ONE,
		STEP_A,
		STEP_B,
		STEP_MARK
	} hrtp_step_t;

	typedef struct packed {
		logic       start;
		logic       long_sc;
		logic       emit_a;
		logic       emit_b;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic       marker;
		logic       bad;
		logic       last;
	} hrtp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hrtp_q_stat_t;

	function automatic logic gets_start(input logic [5:0] nut);
		return nut inside {NUT_TRAIL_R, NUT_BLA_W, NUT_VPS, NUT_SPS, NUT_PPS, NUT_SEI};
	endfunction

	function automatic hrtp_step_t first_step(input hrtp_cmd_t cmd);
		hrtp_step_t s;
		if (cmd.start) begin
			s = cmd.long_sc ? STEP_Z0 : STEP_Z1;
		end else if (cmd.emit_a) begin
			s = STEP_A;
		end else begin
			s = STEP_MARK;
		end
		return s;
	endfunction

endpackage

// ----- hw/rtl/hrtp_in_if.sv -----
`timescale 1ns / 1ps

interface hrtp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       end_of_payload;

	modport source (output valid, output payload_byte, output end_of_payload, input ready);
	modport sink (input valid, input payload_byte, input end_of_payload, output ready);
endinterface

// ----- hw/rtl/hrtp_out_if.sv -----
`timescale 1ns / 1ps

interface hrtp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       out_last;
	logic       bad_fragment;

	modport source (output valid, output out_byte, output has_byte, output out_last,
		output bad_fragment, input ready);
	modport sink (input valid, input out_byte, input has_byte, input out_last,
		input bad_fragment, output ready);
endinterface

// ----- hw/rtl/hrtp_front.sv -----
`timescale 1ns / 1ps

module hrtp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	hrtp_in_if.sink              payload,
	input  logic                 long_sc,
	input  hrtp_pkg::hrtp_q_stat_t q_stat,
	output logic                 push,
	output hrtp_pkg::hrtp_cmd_t  push_cmd
);
	import hrtp_pkg::*;

	hrtp_mode_t mode_q, mode_d;
	logic [7:0] first_q, first_d;
	logic [7:0] second_q, second_d;
	logic       accept;
	logic       bad;
	logic [7:0] b;
	logic [5:0] nut;
	logic [1:0] se;

	assign payload.ready = !q_stat.full;
	assign accept        = payload.valid && payload.ready;
	assign b             = payload.payload_byte;
	assign nut           = b[6:1];
	assign se            = b[7:6];

	always_comb begin
		mode_d   = mode_q;
		first_d  = first_q;
		second_d = second_q;
		bad      = 1'b0;
		push_cmd = '0;
		push_cmd.long_sc = long_sc;
		case (mode_q)
			MODE_IDLE: begin
				if (nut == NUT_FU) begin
					first_d = b;
					mode_d  = MODE_FU_NUH2;
					bad     = payload.end_of_payload;
				end else begin
					push_cmd.start  = gets_start(nut);
					push_cmd.emit_a = 1'b1;
					push_cmd.byte_a = b;
					mode_d          = MODE_PASS;
				end
			end
			MODE_FU_NUH2: begin
				second_d = b;
				mode_d   = MODE_FU_HDR;
				bad      = payload.end_of_payload;
			end
			MODE_FU_HDR: begin
				if (se == SE_BOTH) begin
					mode_d = MODE_DROP;
					bad    = payload.end_of_payload;
				end else begin
					if (se == SE_START) begin
						push_cmd.start  = 1'b1;
						push_cmd.emit_a = 1'b1;
						push_cmd.byte_a = (first_q & HDR_KEEP_MASK) | {1'b0, b[5:0], 1'b0};
						push_cmd.emit_b = 1'b1;
						push_cmd.byte_b = second_q;
					end
					mode_d = MODE_PASS;
				end
			end
			MODE_DROP: begin
				bad = payload.end_of_payload;
			end
			default: begin
				push_cmd.emit_a = 1'b1;
				push_cmd.byte_a = b;
			end
		endcase
		if (payload.end_of_payload) begin
			if (bad) begin
				push_cmd.start  = 1'b0;
				push_cmd.emit_a = 1'b0;
				push_cmd.emit_b = 1'b0;
				push_cmd.marker = 1'b1;
				push_cmd.bad    = 1'b1;
			end else if (!push_cmd.emit_a) begin
				push_cmd.marker = 1'b1;
			end
			push_cmd.last = 1'b1;
			mode_d        = MODE_IDLE;
		end
	end

	assign push = accept && (push_cmd.emit_a || push_cmd.marker);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

endmodule

// ----- hw/rtl/hrtp_queue.sv -----
`timescale 1ns / 1ps

module hrtp_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  hrtp_pkg::hrtp_cmd_t    push_cmd,
	input  logic                   pop,
	output hrtp_pkg::hrtp_cmd_t    head_cmd,
	output hrtp_pkg::hrtp_q_stat_t stat
);
	import hrtp_pkg::*;

	hrtp_cmd_t      entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign stat.full  = (count_q == (QAW + 1)'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- hw/rtl/hrtp_back.sv -----
`timescale 1ns / 1ps

module hrtp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hrtp_pkg::hrtp_cmd_t    head_cmd,
	input  hrtp_pkg::hrtp_q_stat_t q_stat,
	output logic                   pop,
	hrtp_out_if.source             stream
);
	import hrtp_pkg::*;

	hrtp_step_t step_q, step_cur, step_nxt;
	logic       busy_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       has_byte_q;
	logic       out_last_q;
	logic       bad_q;
	logic       load;
	logic       final_word;
	logic [7:0] word_byte;

	assign step_cur   = busy_q ? step_q : first_step(head_cmd);
	assign final_word = (step_cur == STEP_B) || (step_cur == STEP_MARK)
		|| ((step_cur == STEP_A) && !head_cmd.emit_b);
	assign load       = !q_stat.empty && (!out_valid_q || stream.ready);
	assign pop        = load && final_word;

	always_comb begin
		case (step_cur)
			STEP_Z0:   begin step_nxt = STEP_Z1;   word_byte = SC_ZERO;         end
			STEP_Z1:   begin step_nxt = STEP_Z2;   word_byte = SC_ZERO;         end
			STEP_Z2:   begin step_nxt = STEP_ONE;  word_byte = SC_ZERO;         end
			STEP_ONE:  begin step_nxt = STEP_A;    word_byte = SC_ONE;          end
			STEP_A:    begin step_nxt = STEP_B;    word_byte = head_cmd.byte_a; end
			STEP_B:    begin step_nxt = STEP_MARK; word_byte = head_cmd.byte_b; end
			default:   begin step_nxt = STEP_MARK; word_byte = SC_ZERO;         end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_Z0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q      <= !final_word;
				step_q      <= step_nxt;
				out_valid_q <= 1'b1;
			end else if (stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= word_byte;
			has_byte_q <= (step_cur != STEP_MARK);
			out_last_q <= head_cmd.last && final_word;
			bad_q      <= (step_cur == STEP_MARK) && head_cmd.bad;
		end
	end

	assign stream.valid        = out_valid_q;
	assign stream.out_byte     = out_byte_q;
	assign stream.has_byte     = has_byte_q;
	assign stream.out_last     = out_last_q;
	assign stream.bad_fragment = bad_q;

endmodule

// ----- hw/rtl/hevc_rtp_depacketizer_core.sv -----
`timescale 1ns / 1ps
// Channel   Role    Word
// payload   sink    payload_byte[7:0], end_of_payload
// stream    source  out_byte[7:0], has_byte, out_last, bad_fragment
// cfg       write   cfg_wr_en, cfg_wr_data (long_start_code)
//
// Each side moves one word per cycle unless stalled (input: full queue; output: no
// stream.ready). An input byte turns into zero to six output words (start code of
// three or four, rebuilt header of two), sent one a cycle until all are out.
// A four-entry queue decouples the classifier from the back end; input stalls
// only when that queue is full. Reset clears all control state at once.

module hevc_rtp_depacketizer_core (
	input  logic       clk,
	input  logic       arst_n,
	hrtp_in_if.sink    payload,
	hrtp_out_if.source stream,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data
);
	import hrtp_pkg::*;

	logic         long_sc_q;
	logic         push;
	logic         pop;
	hrtp_cmd_t    push_cmd;
	hrtp_cmd_t    head_cmd;
	hrtp_q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_sc_q <= 1'b0;
		end else if (cfg_wr_en) begin
			long_sc_q <= cfg_wr_data;
		end
	end

	hrtp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.payload  (payload),
		.long_sc  (long_sc_q),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	hrtp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	hrtp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_stat   (q_stat),
		.pop      (pop),
		.stream   (stream)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_bad_is_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(stream.valid && stream.bad_fragment) |-> (!stream.has_byte && stream.out_last))
		else $error("bad fragment flag on a data word");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(stream.valid && !stream.has_byte) |-> stream.out_last)
		else $error("bare marker not marked last");

endmodule
